// File: rtl/core/time_advance_grant_coordinator_top_macros.svh
// Assertion macros shared by the time advance grant coordinator modules.
// No dependencies; included by the controller and the datapath.
`ifndef TIME_ADVANCE_GRANT_COORDINATOR_TOP_MACROS_SVH
`define TIME_ADVANCE_GRANT_COORDINATOR_TOP_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define TAGC_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define TAGC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define TAGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/tagc_pkg.sv
// Shared types, constants and time arithmetic of the grant coordinator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tagc_pkg;

    localparam int NumParticipantsDefault = 8;
    localparam int MaxLinksDefault        = 8;
    localparam int ResultCap              = 8;
    localparam int NresWidth              = $clog2(ResultCap + 1);

    localparam logic signed [63:0] TimeNever = {1'b1, 63'd0};
    localparam logic signed [63:0] TimeMax   = {1'b0, {63{1'b1}}};

    typedef enum logic [2:0] {
        CMD_SET_UP    = 3'd0,
        CMD_SET_DOWN  = 3'd1,
        CMD_STARTED   = 3'd2,
        CMD_NEXT      = 3'd3,
        CMD_COMPLETED = 3'd4,
        CMD_RESIGN    = 3'd5,
        CMD_STOP      = 3'd6
    } t_command;

    localparam logic KindGrant = 1'b0;
    localparam logic KindStop  = 1'b1;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_DECODE,
        OP_DS_READ,
        OP_DS_WAIT,
        OP_EX_START,
        OP_EX_READ,
        OP_EX_WAIT,
        OP_EX_CMP,
        OP_CALL,
        OP_RETURN,
        OP_WK_MERGE,
        OP_WK_READ,
        OP_WK_WAIT,
        OP_WK_DONE,
        OP_WK_POP,
        OP_EX_UPNEXT,
        OP_EX_UPCMP,
        OP_EX_END,
        OP_ST_LOOP,
        OP_EMIT,
        OP_FINISH
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_DS_READ,
        S_DS_WAIT,
        S_EX_START,
        S_EX_READ,
        S_EX_WAIT,
        S_EX_CMP,
        S_CALL,
        S_RETURN,
        S_WK_MERGE,
        S_WK_READ,
        S_WK_WAIT,
        S_WK_DONE,
        S_WK_POP,
        S_EX_UPNEXT,
        S_EX_UPCMP,
        S_EX_END,
        S_ST_LOOP,
        S_EMIT,
        S_FINISH
    } t_ctl_state;

    typedef struct packed {
        logic [2:0] cmd;
        logic       p_ok;
        logic       cond;
        logic       cond2;
        logic       hold_valid;
    } t_dp_status;

    // Adds a non-negative delay; never stays never, overflow saturates.
    function automatic logic signed [63:0] f_add_delay(input logic signed [63:0] t,
                                                       input logic [62:0] d);
        logic [64:0] sum;
        sum = {t[63], t} + {2'b00, d};
        if (t == TimeNever) begin
            return TimeNever;
        end else if (sum[64:63] == 2'b01) begin
            return TimeMax;
        end else begin
            return sum[63:0];
        end
    endfunction

    function automatic logic signed [63:0] f_min(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// File: rtl/core/tagc_ctrl.sv
// Sequencer of the grant coordinator: one state per datapath step.
// Depends on tagc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "time_advance_grant_coordinator_top_macros.svh"

module tagc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tagc_pkg::t_dp_status i_st,
    output tagc_pkg::t_dp_op    o_op,
    output logic                o_in_stall
);
    import tagc_pkg::*;

    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_IDLE;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_op       = OP_IDLE;
                o_in_stall = 1'b0;
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                o_op    = OP_DECODE;
                n_state = S_IDLE;
                if (i_st.p_ok) begin
                    case (i_st.cmd)
                        CMD_NEXT:      if (i_st.cond && i_st.cond2) n_state = S_EX_START;
                        CMD_COMPLETED: if (i_st.cond) n_state = S_DS_READ;
                        CMD_STOP:      if (i_st.cond) n_state = S_ST_LOOP;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_DS_READ: begin
                o_op    = OP_DS_READ;
                n_state = i_st.cond ? S_DS_WAIT : S_FINISH;
            end
            S_DS_WAIT: begin
                o_op    = OP_DS_WAIT;
                n_state = i_st.cond ? S_EX_START : S_DS_READ;
            end
            S_EX_START: begin
                o_op    = OP_EX_START;
                n_state = S_EX_READ;
            end
            S_EX_READ: begin
                o_op    = OP_EX_READ;
                n_state = i_st.cond ? S_EX_WAIT : S_EX_END;
            end
            S_EX_WAIT: begin
                o_op    = OP_EX_WAIT;
                n_state = i_st.cond ? S_EX_CMP : S_EX_READ;
            end
            S_EX_CMP: begin
                o_op    = OP_EX_CMP;
                n_state = i_st.cond ? S_CALL : S_EX_READ;
            end
            S_CALL: begin
                o_op    = OP_CALL;
                n_state = i_st.cond ? S_WK_READ : S_RETURN;
            end
            S_RETURN: begin
                o_op    = OP_RETURN;
                n_state = i_st.cond ? S_EX_UPNEXT : S_WK_MERGE;
            end
            S_WK_MERGE: begin
                o_op    = OP_WK_MERGE;
                n_state = S_WK_READ;
            end
            S_WK_READ: begin
                o_op    = OP_WK_READ;
                n_state = i_st.cond ? S_WK_WAIT : S_WK_DONE;
            end
            S_WK_WAIT: begin
                o_op    = OP_WK_WAIT;
                n_state = i_st.cond ? S_CALL : S_WK_READ;
            end
            S_WK_DONE: begin
                o_op    = OP_WK_DONE;
                n_state = i_st.cond ? S_WK_POP : S_RETURN;
            end
            S_WK_POP: begin
                o_op    = OP_WK_POP;
                n_state = S_RETURN;
            end
            S_EX_UPNEXT: begin
                o_op    = OP_EX_UPNEXT;
                n_state = S_EX_UPCMP;
            end
            S_EX_UPCMP: begin
                o_op    = OP_EX_UPCMP;
                n_state = S_EX_READ;
            end
            S_EX_END: begin
                o_op = OP_EX_END;
                if (i_st.cond) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = (i_st.cmd == CMD_COMPLETED) ? S_DS_READ : S_FINISH;
                end
            end
            S_ST_LOOP: begin
                o_op = OP_ST_LOOP;
                if (!i_st.cond) begin
                    n_state = S_FINISH;
                end else if (i_st.cond2) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_op = OP_EMIT;
                if (i_st.cond) begin
                    if (i_st.cmd == CMD_STOP) begin
                        n_state = S_ST_LOOP;
                    end else if (i_st.cmd == CMD_COMPLETED) begin
                        n_state = S_DS_READ;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                o_op = OP_FINISH;
                if (i_st.cond) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `TAGC_ASSERT_IMPL(a_idle_hold_empty, i_clk, i_rst_n, r_state == S_IDLE, !i_st.hold_valid, "result left behind at idle")
    `TAGC_ASSERT_NEXT(a_accept_decodes, i_clk, i_rst_n, r_state == S_IDLE && i_in_valid, r_state == S_DECODE, "accepted beat not decoded")
    `TAGC_ASSERT_IMPL(a_decode_after_idle, i_clk, i_rst_n, r_state == S_DECODE, $past(r_state) == S_IDLE, "decode without accept")

endmodule

// File: rtl/core/tagc_datapath.sv
// Participant tables, link memories, walk stack and result registers.
// Depends on tagc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "time_advance_grant_coordinator_top_macros.svh"

module tagc_datapath #(
    parameter int NUM_PARTICIPANTS = tagc_pkg::NumParticipantsDefault,
    parameter int MAX_LINKS        = tagc_pkg::MaxLinksDefault
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tagc_pkg::t_dp_op     i_op,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_command,
    input  logic [2:0]           i_participant,
    input  logic [2:0]           i_link_slot,
    input  logic [2:0]           i_peer,
    input  logic [62:0]          i_link_delay,
    input  logic [3:0]           i_link_count,
    input  logic signed [63:0]   i_time_value,
    input  logic                 i_out_stall,
    output tagc_pkg::t_dp_status o_st,
    output logic                 o_out_valid,
    output logic                 o_message_kind,
    output logic [2:0]           o_target,
    output logic signed [63:0]   o_message_time,
    output logic                 o_last
);
    import tagc_pkg::*;

    localparam int N   = NUM_PARTICIPANTS;
    localparam int ML  = MAX_LINKS;
    localparam int PW  = (N > 1) ? $clog2(N) : 1;
    localparam int CW  = $clog2(ML + 1);
    localparam int SW  = $clog2(N + 1);
    localparam int IW  = (SW > CW) ? SW : CW;
    localparam int AW  = $clog2(N * ML);
    localparam int DEP = N * ML;

    typedef struct packed {
        logic [PW-1:0]      node;
        logic [CW-1:0]      idx;
        logic signed [63:0] best;
        logic [62:0]        dly;
    } t_frame;

    function automatic logic [AW-1:0] f_addr(input int pi, input int si);
        return AW'(pi * ML + si);
    endfunction

    // Latched command beat.
    logic [2:0]         r_cmd, r_p, r_slot, r_peer;
    logic [62:0]        r_dly;
    logic [3:0]         r_cnt;
    logic signed [63:0] r_t;

    // Participant tables.
    logic signed [63:0] r_ne   [N];
    logic signed [63:0] r_comp [N];
    logic [N-1:0]       r_conn;
    logic [CW-1:0]      r_ucnt [N];
    logic [CW-1:0]      r_dcnt [N];

    // Link memories.
    logic [2:0]  r_up_peer_mem [DEP];
    logic [62:0] r_up_dly_mem  [DEP];
    logic [2:0]  r_dn_peer_mem [DEP];
    logic [2:0]  r_up_q, r_dn_q;
    logic [62:0] r_up_d;

    // Examination and walk state.
    logic [IW-1:0]      r_di;
    logic [PW-1:0]      r_ex, r_eq, r_callnode;
    logic [CW-1:0]      r_j;
    logic signed [63:0] r_cand, r_updone, r_arg, r_ret, r_tmp;
    logic [62:0]        r_ed;
    t_frame             r_cur;
    logic [SW-1:0]      r_depth;
    logic [N-1:0]       r_visited;
    t_frame             r_stack [N];
    t_frame             r_stack_q;

    // Pending and output results.
    logic               r_new_kind, r_hold_kind, r_hold_valid;
    logic [PW-1:0]      r_new_tgt, r_hold_tgt;
    logic signed [63:0] r_new_time, r_hold_time;
    logic [NresWidth-1:0] r_nres;
    logic               r_out_valid, r_out_kind, r_out_last;
    logic [2:0]         r_out_tgt;
    logic signed [63:0] r_out_time;

    logic [PW-1:0]      w_pa;
    logic signed [63:0] w_pa_ne, w_pa_comp;
    logic               w_pa_conn;
    logic [CW-1:0]      w_pa_ucnt, w_pa_dcnt;
    logic               w_p_ok, w_slot_ok, w_out_free, w_enter, w_cap_full;
    logic               w_out_load;
    logic [CW-1:0]      w_cnt_sat;
    logic [AW-1:0]      w_wr_addr, w_up_raddr, w_dn_raddr;
    logic               w_up_we, w_dn_we;

    assign w_p_ok     = int'(r_p) < N;
    assign w_slot_ok  = int'(r_slot) < ML;
    assign w_cnt_sat  = (int'(r_cnt) > ML) ? CW'(ML) : CW'(r_cnt);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cap_full = int'(r_nres) >= ResultCap;
    assign w_out_load = r_hold_valid && w_out_free &&
                        ((i_op == OP_EMIT && !w_cap_full) || i_op == OP_FINISH);
    assign w_wr_addr  = f_addr(int'(r_p), int'(r_slot));
    assign w_dn_raddr = f_addr(int'(r_p), int'(r_di));
    assign w_up_raddr = (i_op == OP_WK_READ) ? f_addr(int'(r_cur.node), int'(r_cur.idx))
                                             : f_addr(int'(r_ex), int'(r_j));
    assign w_up_we = (i_op == OP_DECODE) && w_p_ok && w_slot_ok && (r_cmd == CMD_SET_UP);
    assign w_dn_we = (i_op == OP_DECODE) && w_p_ok && w_slot_ok && (r_cmd == CMD_SET_DOWN);

    // One table read port, steered by the step in progress.
    always_comb begin
        w_pa = PW'(r_p);
        case (i_op) inside
            OP_EX_START, OP_EX_READ, OP_EX_END: w_pa = r_ex;
            OP_EX_WAIT:                         w_pa = PW'(r_up_q);
            OP_EX_CMP:                          w_pa = r_eq;
            OP_CALL:                            w_pa = r_callnode;
            OP_WK_READ, OP_WK_DONE:             w_pa = r_cur.node;
            OP_ST_LOOP:                         w_pa = PW'(r_di);
            default:                            w_pa = PW'(r_p);
        endcase
    end

    assign w_pa_ne   = r_ne[w_pa];
    assign w_pa_comp = r_comp[w_pa];
    assign w_pa_conn = r_conn[w_pa];
    assign w_pa_ucnt = r_ucnt[w_pa];
    assign w_pa_dcnt = r_dcnt[w_pa];
    assign w_enter   = !r_visited[r_callnode] && w_pa_conn;

    always_comb begin
        o_st            = '0;
        o_st.cmd        = r_cmd;
        o_st.p_ok       = w_p_ok;
        o_st.hold_valid = r_hold_valid;
        case (i_op)
            OP_DECODE: begin
                o_st.cond  = w_pa_conn;
                o_st.cond2 = w_pa_ucnt != '0;
            end
            OP_DS_READ:  o_st.cond = int'(r_di) < int'(w_pa_dcnt);
            OP_DS_WAIT:  o_st.cond = int'(r_dn_q) < N;
            OP_EX_READ:  o_st.cond = int'(r_j) < int'(w_pa_ucnt);
            OP_EX_WAIT:  o_st.cond = int'(r_up_q) < N;
            OP_EX_CMP:   o_st.cond = r_updone < r_cand;
            OP_CALL:     o_st.cond = w_enter;
            OP_RETURN:   o_st.cond = r_depth == '0;
            OP_WK_READ:  o_st.cond = int'(r_cur.idx) < int'(w_pa_ucnt);
            OP_WK_WAIT:  o_st.cond = int'(r_up_q) < N;
            OP_WK_DONE:  o_st.cond = int'(r_depth) > 1;
            OP_EX_END:   o_st.cond = (r_cand > w_pa_comp) && w_pa_conn;
            OP_ST_LOOP: begin
                o_st.cond  = int'(r_di) < N;
                o_st.cond2 = (int'(r_di) < N) && (int'(r_di) != int'(r_p)) && w_pa_conn;
            end
            OP_EMIT:     o_st.cond = w_cap_full || !r_hold_valid || w_out_free;
            OP_FINISH:   o_st.cond = !r_hold_valid || w_out_free;
            default:     o_st.cond = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_up_we) begin
            r_up_peer_mem[w_wr_addr] <= r_peer;
            r_up_dly_mem[w_wr_addr]  <= r_dly;
        end
        r_up_q <= r_up_peer_mem[w_up_raddr];
        r_up_d <= r_up_dly_mem[w_up_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_dn_we) begin
            r_dn_peer_mem[w_wr_addr] <= r_peer;
        end
        r_dn_q <= r_dn_peer_mem[w_dn_raddr];
    end

    // The walk keeps its current frame in registers; callers wait here.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_CALL && w_enter && r_depth != '0) begin
            r_stack[PW'(r_depth - SW'(1))] <= r_cur;
        end
        r_stack_q <= r_stack[PW'(r_depth - SW'(2))];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N; k++) begin
                r_ne[k]   <= TimeNever;
                r_comp[k] <= TimeNever;
                r_ucnt[k] <= '0;
                r_dcnt[k] <= '0;
            end
            r_conn       <= '0;
            r_visited    <= '0;
            r_depth      <= '0;
            r_hold_valid <= 1'b0;
            r_nres       <= '0;
            r_out_valid  <= 1'b0;
            r_di         <= '0;
            r_j          <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_out_load) r_out_valid <= 1'b0;
            case (i_op)
                OP_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd  <= i_command;
                        r_p    <= i_participant;
                        r_slot <= i_link_slot;
                        r_peer <= i_peer;
                        r_dly  <= i_link_delay;
                        r_cnt  <= i_link_count;
                        r_t    <= i_time_value;
                        r_nres <= '0;
                    end
                end
                OP_DECODE: begin
                    r_di <= '0;
                    // A next event report examines the reporting participant itself.
                    r_ex <= PW'(r_p);
                    if (w_p_ok) begin
                        case (r_cmd)
                            CMD_SET_UP:    if (w_slot_ok) r_ucnt[PW'(r_p)] <= w_cnt_sat;
                            CMD_SET_DOWN:  if (w_slot_ok) r_dcnt[PW'(r_p)] <= w_cnt_sat;
                            CMD_STARTED:   r_conn[PW'(r_p)] <= 1'b1;
                            CMD_RESIGN:    r_conn[PW'(r_p)] <= 1'b0;
                            CMD_NEXT:      if (w_pa_conn) r_ne[PW'(r_p)] <= r_t;
                            CMD_COMPLETED: if (w_pa_conn) r_comp[PW'(r_p)] <= r_t;
                            default: ;
                        endcase
                    end
                end
                OP_DS_WAIT: begin
                    r_di <= r_di + IW'(1);
                    r_ex <= PW'(r_dn_q);
                end
                OP_EX_START: begin
                    r_cand <= w_pa_ne;
                    r_j    <= '0;
                end
                OP_EX_WAIT: begin
                    if (int'(r_up_q) < N) begin
                        r_eq     <= PW'(r_up_q);
                        r_ed     <= r_up_d;
                        r_updone <= f_add_delay(w_pa_comp, r_up_d);
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                OP_EX_CMP: begin
                    if (r_updone < r_cand) begin
                        r_visited  <= '0;
                        r_arg      <= w_pa_ne;
                        r_callnode <= r_eq;
                        r_depth    <= '0;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                OP_CALL: begin
                    r_visited[r_callnode] <= 1'b1;
                    if (w_enter) begin
                        r_depth     <= r_depth + SW'(1);
                        r_cur.node  <= r_callnode;
                        r_cur.idx   <= '0;
                        r_cur.best  <= f_min(w_pa_ne, r_arg);
                    end else begin
                        r_ret <= r_arg;
                    end
                end
                OP_RETURN: begin
                    r_tmp <= f_add_delay(r_ret, r_cur.dly);
                end
                OP_WK_MERGE: begin
                    if (r_tmp < r_cur.best) r_cur.best <= r_tmp;
                    r_cur.idx <= r_cur.idx + CW'(1);
                end
                OP_WK_WAIT: begin
                    if (int'(r_up_q) < N) begin
                        r_cur.dly  <= r_up_d;
                        r_arg      <= r_cur.best;
                        r_callnode <= PW'(r_up_q);
                    end else begin
                        r_cur.idx <= r_cur.idx + CW'(1);
                    end
                end
                OP_WK_DONE: begin
                    r_ret   <= (r_cur.best == TimeNever) ? w_pa_comp : r_cur.best;
                    r_depth <= r_depth - SW'(1);
                end
                OP_WK_POP: begin
                    r_cur <= r_stack_q;
                end
                OP_EX_UPNEXT: begin
                    r_tmp <= f_add_delay(r_ret, r_ed);
                end
                OP_EX_UPCMP: begin
                    if (r_tmp <= r_cand) r_cand <= r_updone;
                    r_j <= r_j + CW'(1);
                end
                OP_EX_END: begin
                    r_new_kind <= KindGrant;
                    r_new_tgt  <= r_ex;
                    r_new_time <= r_cand;
                end
                OP_ST_LOOP: begin
                    if (int'(r_di) < N) r_di <= r_di + IW'(1);
                    r_new_kind <= KindStop;
                    r_new_tgt  <= PW'(r_di);
                    r_new_time <= r_t;
                end
                OP_EMIT: begin
                    // A result is held back one step so the final one can carry last.
                    if (!w_cap_full && (!r_hold_valid || w_out_free)) begin
                        if (r_hold_valid) begin
                            r_out_valid <= 1'b1;
                            r_out_kind  <= r_hold_kind;
                            r_out_tgt   <= 3'(r_hold_tgt);
                            r_out_time  <= r_hold_time;
                            r_out_last  <= 1'b0;
                        end
                        r_hold_valid <= 1'b1;
                        r_hold_kind  <= r_new_kind;
                        r_hold_tgt   <= r_new_tgt;
                        r_hold_time  <= r_new_time;
                        r_nres       <= r_nres + NresWidth'(1);
                    end
                end
                OP_FINISH: begin
                    if (r_hold_valid && w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_kind   <= r_hold_kind;
                        r_out_tgt    <= 3'(r_hold_tgt);
                        r_out_time   <= r_hold_time;
                        r_out_last   <= 1'b1;
                        r_hold_valid <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_message_kind = r_out_kind;
    assign o_target       = r_out_tgt;
    assign o_message_time = r_out_time;
    assign o_last         = r_out_last;

    `TAGC_ASSERT_HOLDS(a_depth_bound, i_clk, i_rst_n, int'(r_depth) <= N, "walk deeper than the participant count")
    `TAGC_ASSERT_HOLDS(a_result_cap, i_clk, i_rst_n, int'(r_nres) <= ResultCap, "result count above cap")
    `TAGC_ASSERT_NEXT(a_call_marks, i_clk, i_rst_n, i_op == OP_CALL, r_visited != '0, "walk call left no visited mark")

endmodule

// File: rtl/core/time_advance_grant_coordinator_top.sv
// Sequencing: link, start and resign beats are decoded and done; a completed report steps
// through each downstream link, a report through every upstream link examined, and a walk
// through each of its links and each walked participant.
// Throughput: one beat at a time; results are held one step so the final one carries last,
// and a stalled output holds the sequencer until the last result is loaded.
// Reset (synchronous, active low) sets the participant times to never and clears flags and counts.
`timescale 1ns / 1ps

module time_advance_grant_coordinator_top #(
    parameter int NUM_PARTICIPANTS = tagc_pkg::NumParticipantsDefault,
    parameter int MAX_LINKS        = tagc_pkg::MaxLinksDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic [2:0]         i_participant,
    input  logic [2:0]         i_link_slot,
    input  logic [2:0]         i_peer,
    input  logic [62:0]        i_link_delay,
    input  logic [3:0]         i_link_count,
    input  logic signed [63:0] i_time_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_message_kind,
    output logic [2:0]         o_target,
    output logic signed [63:0] o_message_time,
    output logic               o_last
);
    import tagc_pkg::*;

    t_dp_op     w_op;
    t_dp_status w_st;

    tagc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (w_st),
        .o_op       (w_op),
        .o_in_stall (o_in_stall)
    );

    tagc_datapath #(
        .NUM_PARTICIPANTS (NUM_PARTICIPANTS),
        .MAX_LINKS        (MAX_LINKS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_in_valid     (i_in_valid),
        .i_command      (i_command),
        .i_participant  (i_participant),
        .i_link_slot    (i_link_slot),
        .i_peer         (i_peer),
        .i_link_delay   (i_link_delay),
        .i_link_count   (i_link_count),
        .i_time_value   (i_time_value),
        .i_out_stall    (i_out_stall),
        .o_st           (w_st),
        .o_out_valid    (o_out_valid),
        .o_message_kind (o_message_kind),
        .o_target       (o_target),
        .o_message_time (o_message_time),
        .o_last         (o_last)
    );

endmodule
